// File: rtl/core/svl_pkg.sv
// svl_pkg: shared constants of the stereo VU level meter.
// Register indexes, fixed field widths and reset values; no dependencies.
package svl_pkg;

	localparam int TOP_BITS = 8;   // sample bits kept before squaring
	localparam int SQ_W     = 15;  // width of one square (0..16384)
	localparam int WLEN_W   = 13;  // window_len register width
	localparam int DAMP_W   = 16;  // damping register width, Q0.16
	localparam int CFG_W    = 16;  // config write data width
	localparam int CFG_IDX_W = 2;  // config register index width
	localparam int LEVEL_W  = 15;  // emitted level width

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 2'd1;

	localparam logic [WLEN_W-1:0] WINDOW_RESET  = 13'd2048;
	localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd9830;

	localparam logic KIND_PAIR = 1'b0;
	localparam logic KIND_IDLE = 1'b1;

endpackage

// File: rtl/core/svl_fifo.sv
// svl_fifo: small register queue with push/full and pop/valid sides.
// Generic payload width and depth; no package dependencies.
module svl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             valid
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign valid   = (count_q != '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/svl_front.sv
// svl_front: accepts beats, squares the top sample bits and sums per channel.
// Emits one job per finished window or idle beat. Uses svl_pkg.
module svl_front #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int SUM_W       = 27,
	parameter int LEN_W       = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         kind,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic [svl_pkg::WLEN_W-1:0]   window_len,
	output logic                         job_push,
	output logic [2*SUM_W+LEN_W-1:0]     job_data
);
	import svl_pkg::*;

	logic [SUM_W-1:0] left_sum_q, right_sum_q;
	logic [LEN_W-1:0] pair_count_q;
	logic [31:0] wl32, eff32;
	logic [LEN_W-1:0] eff_len, count_next;
	logic signed [SAMPLE_BITS-1:0] lsh, rsh;
	logic signed [TOP_BITS-1:0] top_l, top_r;
	logic signed [2*TOP_BITS-1:0] sq_l, sq_r;
	logic [SUM_W-1:0] lsum_next, rsum_next;
	logic win_done, is_idle;

	// Clamp the window length to 1..MAX_WINDOW.
	always_comb begin
		wl32 = 32'(window_len);
		if (wl32 == 32'd0) begin
			eff32 = 32'd1;
		end else if (wl32 > 32'(MAX_WINDOW)) begin
			eff32 = 32'(MAX_WINDOW);
		end else begin
			eff32 = wl32;
		end
		eff_len = eff32[LEN_W-1:0];
	end

	assign lsh   = left_sample >>> (SAMPLE_BITS - TOP_BITS);
	assign rsh   = right_sample >>> (SAMPLE_BITS - TOP_BITS);
	assign top_l = lsh[TOP_BITS-1:0];
	assign top_r = rsh[TOP_BITS-1:0];
	assign sq_l  = top_l * top_l;
	assign sq_r  = top_r * top_r;

	assign lsum_next  = left_sum_q + SUM_W'(sq_l[SQ_W-1:0]);
	assign rsum_next  = right_sum_q + SUM_W'(sq_r[SQ_W-1:0]);
	assign count_next = pair_count_q + 1'b1;
	assign is_idle    = (kind == KIND_IDLE);
	// End the window once the count reaches or passes the current length.
	assign win_done   = (count_next >= eff_len);

	assign job_push = accept & (is_idle | win_done);
	assign job_data = is_idle ? {{SUM_W{1'b0}}, {SUM_W{1'b0}}, LEN_W'(1)}
	                          : {lsum_next, rsum_next, eff_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q   <= '0;
			right_sum_q  <= '0;
			pair_count_q <= '0;
		end else if (accept) begin
			if (is_idle || win_done) begin
				left_sum_q   <= '0;
				right_sum_q  <= '0;
				pair_count_q <= '0;
			end else begin
				left_sum_q   <= lsum_next;
				right_sum_q  <= rsum_next;
				pair_count_q <= count_next;
			end
		end
	end

endmodule

// File: rtl/core/svl_back.sv
// svl_back: divides each window sum by its length, one quotient bit a cycle,
// then smooths both levels with a split multiply. Uses svl_pkg.
module svl_back #(
	parameter int SUM_W     = 27,
	parameter int LEN_W     = 13,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  logic [2*SUM_W+LEN_W-1:0]     job_data,
	output logic                         job_pop,
	input  logic [svl_pkg::DAMP_W-1:0]   damping,
	input  logic                         res_full,
	output logic                         res_push,
	output logic [2*svl_pkg::LEVEL_W-1:0] res_data
);
	import svl_pkg::*;

	localparam int LVL_W = SUM_W + FRAC_BITS;
	localparam int HALF  = (LVL_W + 1) / 2;
	localparam int HI_W  = LVL_W - HALF;
	localparam int P_W   = LVL_W + DAMP_W;
	localparam int STEP_CNT_W = $clog2(SUM_W);
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(SUM_W - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0] state_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [LEN_W-1:0] len_q;
	logic [SUM_W-1:0] quo_l_q, quo_r_q;
	logic [LEN_W-1:0] rem_l_q, rem_r_q;
	logic [LVL_W-1:0] left_smoothed_q, right_smoothed_q;
	logic [HALF+DAMP_W-1:0] plo_l_q, plo_r_q;
	logic [HI_W+DAMP_W-1:0] phi_l_q, phi_r_q;
	logic neg_l_q, neg_r_q;

	logic [LEN_W:0] trial_l, trial_r, diff_tl, diff_tr;
	logic bit_l, bit_r;
	logic signed [LVL_W:0] diff_l, diff_r;
	logic [LVL_W:0] absd_l, absd_r;
	logic [P_W-1:0] p_l, p_r;
	logic [P_W:0] pc_l, pc_r;
	logic [LVL_W-1:0] step_l, step_r, lvl_l_next, lvl_r_next;

	// Restoring division step for both channels.
	assign trial_l = {rem_l_q, quo_l_q[SUM_W-1]};
	assign trial_r = {rem_r_q, quo_r_q[SUM_W-1]};
	assign diff_tl = trial_l - {1'b0, len_q};
	assign diff_tr = trial_r - {1'b0, len_q};
	assign bit_l   = (trial_l >= {1'b0, len_q});
	assign bit_r   = (trial_r >= {1'b0, len_q});

	// Signed distance from level to the new target mean.
	assign diff_l = $signed({1'b0, quo_l_q, {FRAC_BITS{1'b0}}})
	              - $signed({1'b0, left_smoothed_q});
	assign diff_r = $signed({1'b0, quo_r_q, {FRAC_BITS{1'b0}}})
	              - $signed({1'b0, right_smoothed_q});
	assign absd_l = diff_l[LVL_W] ? LVL_W'(-diff_l) : LVL_W'(diff_l);
	assign absd_r = diff_r[LVL_W] ? LVL_W'(-diff_r) : LVL_W'(diff_r);

	// Recombine partial products; a negative step rounds away from zero (floor).
	assign p_l  = (P_W'(phi_l_q) << HALF) + P_W'(plo_l_q);
	assign p_r  = (P_W'(phi_r_q) << HALF) + P_W'(plo_r_q);
	assign pc_l = {1'b0, p_l} + (neg_l_q ? (P_W+1)'({DAMP_W{1'b1}}) : '0);
	assign pc_r = {1'b0, p_r} + (neg_r_q ? (P_W+1)'({DAMP_W{1'b1}}) : '0);
	assign step_l = pc_l[DAMP_W +: LVL_W];
	assign step_r = pc_r[DAMP_W +: LVL_W];
	assign lvl_l_next = neg_l_q ? left_smoothed_q - step_l : left_smoothed_q + step_l;
	assign lvl_r_next = neg_r_q ? right_smoothed_q - step_r : right_smoothed_q + step_r;

	assign job_pop  = (state_q == ST_IDLE) & job_valid;
	assign res_push = (state_q == ST_UPD) & ~res_full;
	assign res_data = {lvl_l_next[FRAC_BITS +: LEVEL_W], lvl_r_next[FRAC_BITS +: LEVEL_W]};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_l_q <= job_data[LEN_W+SUM_W +: SUM_W];
				quo_r_q <= job_data[LEN_W +: SUM_W];
				len_q   <= job_data[LEN_W-1:0];
				rem_l_q <= '0;
				rem_r_q <= '0;
			end
			ST_DIV: begin
				quo_l_q <= {quo_l_q[SUM_W-2:0], bit_l};
				quo_r_q <= {quo_r_q[SUM_W-2:0], bit_r};
				rem_l_q <= bit_l ? diff_tl[LEN_W-1:0] : trial_l[LEN_W-1:0];
				rem_r_q <= bit_r ? diff_tr[LEN_W-1:0] : trial_r[LEN_W-1:0];
			end
			ST_MUL: begin
				plo_l_q <= absd_l[HALF-1:0] * damping;
				phi_l_q <= absd_l[LVL_W-1:HALF] * damping;
				plo_r_q <= absd_r[HALF-1:0] * damping;
				phi_r_q <= absd_r[LVL_W-1:HALF] * damping;
				neg_l_q <= diff_l[LVL_W];
				neg_r_q <= diff_r[LVL_W];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			step_q           <= '0;
			left_smoothed_q  <= '0;
			right_smoothed_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					// Hold until the result queue has room.
					if (!res_full) begin
						left_smoothed_q  <= lvl_l_next;
						right_smoothed_q <= lvl_r_next;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/stereo_vu_level_meter_top.sv
// stereo_vu_level_meter_top: top level of the stereo VU level meter.
// Instantiates svl_front, svl_fifo and svl_back; uses svl_pkg.
//
// Push one beat per stereo pair (kind = pair) or an idle beat (kind = idle,
// sample ports ignored). Each pair beat cuts both samples to their top 8
// bits, squares them and adds the squares to a per-channel sum; after
// window_len pairs (0 counts as 1, values above MAX_WINDOW clamp to it)
// the front hands both sums to a two-entry job queue and clears them. An
// idle beat hands over zero sums at once. The back end divides each sum by
// the window length with a restoring divider, one quotient bit per cycle,
// then moves each level toward its mean by the damping factor (Q0.16, with
// the step floored) and pushes the integer part of both levels into a
// two-entry result queue. The front accepts a beat whenever the job queue
// is not full; each window end or idle beat then passes through the back
// end's load, bit-serial divide, multiply and update states, and the back
// end takes the next job only after the update, which waits while the result
// queue is full. full rises only while the job queue is full. Write registers
// only while the block has no work in flight.
module stereo_vu_level_meter_top #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input beats
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	// Result beats
	output logic                          empty,
	input  logic                          pop,
	output logic [svl_pkg::LEVEL_W-1:0]   left_level,
	output logic [svl_pkg::LEVEL_W-1:0]   right_level,
	// Register writes
	input  logic                          write_en,
	input  logic [svl_pkg::CFG_IDX_W-1:0] write_index,
	input  logic [svl_pkg::CFG_W-1:0]     write_data
);
	import svl_pkg::*;

	// Sums hold up to 16384 * MAX_WINDOW.
	localparam int SUM_W = $clog2(16384 * MAX_WINDOW + 1);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int JOB_W = 2 * SUM_W + LEN_W;
	localparam int RES_W = 2 * LEVEL_W;

	logic [WLEN_W-1:0] window_len_q;
	logic [DAMP_W-1:0] damping_q;

	logic accept;
	logic job_push, job_full, job_valid, job_pop;
	logic [JOB_W-1:0] job_wdata, job_rdata;
	logic res_push, res_full, res_valid;
	logic [RES_W-1:0] res_wdata, res_rdata;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_RESET;
			damping_q    <= DAMPING_RESET;
		end else if (write_en) begin
			case (write_index)
				REG_WINDOW_LEN: window_len_q <= write_data[WLEN_W-1:0];
				REG_DAMPING:    damping_q    <= write_data[DAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stall inputs only while the job queue cannot take a window end.
	assign full   = job_full;
	assign accept = push & ~job_full;

	svl_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W),
		.LEN_W       (LEN_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (kind),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.window_len   (window_len_q),
		.job_push     (job_push),
		.job_data     (job_wdata)
	);

	svl_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (2)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.valid  (job_valid)
	);

	svl_back #(
		.SUM_W     (SUM_W),
		.LEN_W     (LEN_W),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_rdata),
		.job_pop   (job_pop),
		.damping   (damping_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wdata)
	);

	// Hold finished levels until the consumer pops them.
	svl_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.valid  (res_valid)
	);

	assign empty       = ~res_valid;
	assign left_level  = res_rdata[RES_W-1:LEVEL_W];
	assign right_level = res_rdata[LEVEL_W-1:0];

endmodule
